>>> hw/rtl/blm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blm_pkg: shared types, constants and microcode for the battery level monitor
// Holds register indexes, fixed field widths, the control word layout and the
// sequencer program ROM.
// ----------------------------------------------------------------------------
package blm_pkg;

	// Parameter defaults
	localparam int FRAC_BITS_DEF   = 8;
	localparam int ADC_MV_BITS_DEF = 12;

	// Fixed widths
	localparam int MV_INT_BITS = 14;
	localparam int GAIN_W      = 11;
	localparam int ALPHA_W     = 7;
	localparam int PCT_W       = 7;
	localparam int REP_PCT_W   = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 14;
	localparam int GAIN_SHIFT  = 8;

	// Constants
	localparam logic [ALPHA_W-1:0]   PCT_FULL       = 7'd100;
	localparam logic [REP_PCT_W-1:0] RESET_REPORTED = 8'd255;

	// Register reset values
	localparam logic [MV_INT_BITS-1:0] FULL_MV_RST  = 14'd4200;
	localparam logic [MV_INT_BITS-1:0] EMPTY_MV_RST = 14'd3300;
	localparam logic [MV_INT_BITS-1:0] CHG_MV_RST   = 14'd4250;
	localparam logic [GAIN_W-1:0]      GAIN_RST     = 11'd512;
	localparam logic [ALPHA_W-1:0]     ALPHA_RST    = 7'd15;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MV     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGING_MV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q8     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PCT   = 3'd4;

	// Datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_CAPTURE  = 4'd1;
	localparam op_t OP_MULG     = 4'd2;
	localparam op_t OP_PACK     = 4'd3;
	localparam op_t OP_SEED     = 4'd4;
	localparam op_t OP_MUL_NEW  = 4'd5;
	localparam op_t OP_MUL_OLD  = 4'd6;
	localparam op_t OP_DIV_EMA  = 4'd7;
	localparam op_t OP_SMTH_WB  = 4'd8;
	localparam op_t OP_LEVEL    = 4'd9;
	localparam op_t OP_OFFSET   = 4'd10;
	localparam op_t OP_DIV_LVL  = 4'd11;
	localparam op_t OP_PCT_WB   = 4'd12;
	localparam op_t OP_REPORT   = 4'd13;

	// Jump conditions
	typedef logic [2:0] cond_t;
	localparam cond_t C_NEVER    = 3'd0;
	localparam cond_t C_ALWAYS   = 3'd1;
	localparam cond_t C_NO_ITEM  = 3'd2;
	localparam cond_t C_HAVE     = 3'd3;
	localparam cond_t C_DIV_BUSY = 3'd4;
	localparam cond_t C_CLAMP    = 3'd5;
	localparam cond_t C_OUT_BUSY = 3'd6;

	// Step addresses
	typedef logic [3:0] step_t;
	localparam step_t S_WAIT     = 4'd0;
	localparam step_t S_MULG     = 4'd1;
	localparam step_t S_PACK     = 4'd2;
	localparam step_t S_SEED     = 4'd3;
	localparam step_t S_MUL_NEW  = 4'd4;
	localparam step_t S_MUL_OLD  = 4'd5;
	localparam step_t S_DIV_EMA  = 4'd6;
	localparam step_t S_WAIT_EMA = 4'd7;
	localparam step_t S_SMTH_WB  = 4'd8;
	localparam step_t S_LEVEL    = 4'd9;
	localparam step_t S_OFFSET   = 4'd10;
	localparam step_t S_DIV_LVL  = 4'd11;
	localparam step_t S_WAIT_LVL = 4'd12;
	localparam step_t S_PCT_WB   = 4'd13;
	localparam step_t S_REPORT   = 4'd14;
	localparam step_t S_RETURN   = 4'd15;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Program ROM: a taken jump goes to target, otherwise to the next step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
		case (step)
			S_WAIT:     w = '{op: OP_CAPTURE, cond: C_NO_ITEM,  target: S_WAIT};
			S_MULG:     w = '{op: OP_MULG,    cond: C_NEVER,    target: S_WAIT};
			S_PACK:     w = '{op: OP_PACK,    cond: C_HAVE,     target: S_MUL_NEW};
			S_SEED:     w = '{op: OP_SEED,    cond: C_ALWAYS,   target: S_LEVEL};
			S_MUL_NEW:  w = '{op: OP_MUL_NEW, cond: C_NEVER,    target: S_WAIT};
			S_MUL_OLD:  w = '{op: OP_MUL_OLD, cond: C_NEVER,    target: S_WAIT};
			S_DIV_EMA:  w = '{op: OP_DIV_EMA, cond: C_NEVER,    target: S_WAIT};
			S_WAIT_EMA: w = '{op: OP_NOP,     cond: C_NEVER,    target: S_WAIT};
			S_SMTH_WB:  w = '{op: OP_SMTH_WB, cond: C_NEVER,    target: S_WAIT};
			S_LEVEL:    w = '{op: OP_LEVEL,   cond: C_CLAMP,    target: S_REPORT};
			S_OFFSET:   w = '{op: OP_OFFSET,  cond: C_NEVER,    target: S_WAIT};
			S_DIV_LVL:  w = '{op: OP_DIV_LVL, cond: C_NEVER,    target: S_WAIT};
			S_WAIT_LVL: w = '{op: OP_NOP,     cond: C_DIV_BUSY, target: S_WAIT_LVL};
			S_PCT_WB:   w = '{op: OP_PCT_WB,  cond: C_NEVER,    target: S_WAIT};
			S_REPORT:   w = '{op: OP_REPORT,  cond: C_OUT_BUSY, target: S_REPORT};
			S_RETURN:   w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_WAIT};
			default:    w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/blm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blm_div: restoring radix-2 divider
// One quotient bit per cycle; busy stays high from start until the last quotient bit is shifted in.
// ----------------------------------------------------------------------------
module blm_div #(
	parameter int DIVIDEND_W = 29,
	parameter int DIVISOR_W  = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       busy,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DIVISOR_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/battery_level_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_level_monitor: smoothed pack voltage to charge percent
// Scales ADC samples by the divider gain, keeps an exponential average and
// reports percent, a charging flag and a change flag per valid sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word: adc_mv and sample_ok.
//   A word with sample_ok low is taken and dropped; it causes no result.
//   Each valid word gives one result word on out_valid/out_stall:
//   percent (0..100), charging and changed.
//   A microcode sequencer steps a small datapath. The average divides by 100
//   with a shift and a reciprocal multiply in one step; the level divides by
//   the span in a bit-serial divider. The first sample seeds the average and
//   skips the averaging steps. A level that clamps at 0 or 100 skips the
//   divider.
//   in_stall is low only while the sequencer waits at its first step.
//   The result sits in an output register; a new word is taken while it waits.
//   If the receiver stalls, the next result waits at the report step.
//   Reset clears the average, restores the register defaults and forces the
//   first result to report a change.
// ----------------------------------------------------------------------------
module battery_level_monitor #(
	parameter int FRAC_BITS   = blm_pkg::FRAC_BITS_DEF,
	parameter int ADC_MV_BITS = blm_pkg::ADC_MV_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [blm_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ADC_MV_BITS-1:0]         adc_mv,
	input  wire logic                           sample_ok,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [blm_pkg::PCT_W-1:0]           percent,
	output logic                                charging,
	output logic                                changed
);

	import blm_pkg::*;

	localparam int SMOOTH_W = MV_INT_BITS + FRAC_BITS;
	localparam int PROD_W   = ADC_MV_BITS + GAIN_W;
	localparam int PACK_W   = PROD_W + FRAC_BITS;
	localparam int ACC_W    = SMOOTH_W + ALPHA_W;
	localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = '1;

	// Divide by 100 as a shift by 2, then a multiply by 1/25 rounded up;
	// the extra 3 shift bits keep it exact for any dividend below 2^ACC_W
	localparam int QSHIFT_25 = ACC_W + 3;
	localparam int RCP_W     = QSHIFT_25 - 4;
	localparam int RPROD_W   = ACC_W - 2 + RCP_W;
	localparam logic [RCP_W-1:0] RCP_25 =
		RCP_W'(((64'd1 << QSHIFT_25) + 64'd24) / 64'd25);

	// Configuration registers
	logic [MV_INT_BITS-1:0] full_q, empty_q, chg_mv_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [ALPHA_W-1:0]     alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q   <= FULL_MV_RST;
			empty_q  <= EMPTY_MV_RST;
			chg_mv_q <= CHG_MV_RST;
			gain_q   <= GAIN_RST;
			alpha_q  <= ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FULL_MV:     full_q   <= cfg_data;
				REG_EMPTY_MV:    empty_q  <= cfg_data;
				REG_CHARGING_MV: chg_mv_q <= cfg_data;
				REG_GAIN_Q8:     gain_q   <= cfg_data[GAIN_W-1:0];
				REG_ALPHA_PCT:   alpha_q  <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	step_t step_q, step_d;
	ctrl_t cw;
	logic  take;
	logic  in_acc;
	logic  out_busy;
	logic  clamp;
	logic  div_busy;
	logic  div_start;
	logic  have_q;

	assign cw       = ucode(step_q);
	assign in_stall = step_q != S_WAIT;
	assign in_acc   = in_valid && !in_stall;
	assign out_busy = out_valid && out_stall;

	always_comb begin
		case (cw.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_ITEM:  take = !(in_acc && sample_ok);
			C_HAVE:     take = have_q;
			C_DIV_BUSY: take = div_busy;
			C_CLAMP:    take = clamp;
			C_OUT_BUSY: take = out_busy;
			default:    take = 1'b1;
		endcase
		step_d = take ? cw.target : step_t'(step_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// Datapath registers
	logic [ADC_MV_BITS-1:0] adc_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SMOOTH_W-1:0]    pack_q;
	logic [SMOOTH_W-1:0]    smooth_q;
	logic [ACC_W-1:0]       acc_q;
	logic [PCT_W-1:0]       pct_q;
	logic                   chg_q;

	// Derived values
	logic [PACK_W-1:0]      pack_wide;
	logic [ALPHA_W-1:0]     alpha_eff, beta;
	logic [MV_INT_BITS-1:0] mv_int, span, off;
	logic [ACC_W-1:0]       quotient;
	logic [RPROD_W-1:0]     ema_prod;

	assign pack_wide = (PACK_W'(prod_q) << FRAC_BITS) >> GAIN_SHIFT;
	assign alpha_eff = (alpha_q > PCT_FULL) ? PCT_FULL : alpha_q;
	assign beta      = PCT_FULL - alpha_eff;
	assign mv_int    = MV_INT_BITS'(smooth_q >> FRAC_BITS);
	assign span      = full_q - empty_q;
	assign off       = mv_int - empty_q;
	assign clamp     = (mv_int >= full_q) || (mv_int <= empty_q);
	assign ema_prod  = RPROD_W'(acc_q >> 2) * RPROD_W'(RCP_25);

	assign div_start = cw.op == OP_DIV_LVL;

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_CAPTURE: adc_q  <= adc_mv;
			OP_MULG:    prod_q <= PROD_W'(adc_q) * PROD_W'(gain_q);
			OP_PACK: begin
				pack_q <= (pack_wide > PACK_W'(SMOOTH_MAX)) ? SMOOTH_MAX
					: pack_wide[SMOOTH_W-1:0];
			end
			OP_MUL_NEW: acc_q <= ACC_W'(pack_q) * ACC_W'(alpha_eff);
			OP_MUL_OLD: acc_q <= acc_q + ACC_W'(smooth_q) * ACC_W'(beta);
			// weighted sum over 100
			OP_DIV_EMA: acc_q <= ACC_W'(ema_prod >> QSHIFT_25);
			OP_LEVEL: begin
				pct_q <= (mv_int >= full_q) ? PCT_FULL : '0;
				chg_q <= mv_int > chg_mv_q;
			end
			OP_OFFSET: begin
				acc_q <= ACC_W'(off) * ACC_W'(PCT_FULL) + ACC_W'(span >> 1);
			end
			OP_PCT_WB: pct_q <= quotient[PCT_W-1:0];
			default: ;
		endcase
	end

	// Average and seed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			have_q   <= 1'b0;
		end else if (cw.op == OP_SEED) begin
			smooth_q <= pack_q;
			have_q   <= 1'b1;
		end else if (cw.op == OP_SMTH_WB) begin
			smooth_q <= (acc_q > ACC_W'(SMOOTH_MAX)) ? SMOOTH_MAX
				: acc_q[SMOOTH_W-1:0];
		end
	end

	// Level divider: scaled offset over the span
	blm_div #(
		.DIVIDEND_W (ACC_W),
		.DIVISOR_W  (MV_INT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (span),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Report: output word and last reported pair
	logic                 out_valid_q;
	logic [PCT_W-1:0]     out_pct_q;
	logic                 out_chg_q, out_changed_q;
	logic [REP_PCT_W-1:0] rep_pct_q;
	logic                 rep_chg_q;
	logic                 out_load;
	logic                 diff;

	assign out_load = (cw.op == OP_REPORT) && !out_busy;
	assign diff     = ({1'b0, pct_q} != rep_pct_q) || (chg_q != rep_chg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rep_pct_q   <= RESET_REPORTED;
			rep_chg_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load && diff) begin
				rep_pct_q <= {1'b0, pct_q};
				rep_chg_q <= chg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pct_q     <= pct_q;
			out_chg_q     <= chg_q;
			out_changed_q <= diff;
		end
	end

	assign out_valid = out_valid_q;
	assign percent   = out_pct_q;
	assign charging  = out_chg_q;
	assign changed   = out_changed_q;

	// Checks
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_pct_q <= PCT_FULL)
		else $error("percent above full scale");

	a_have_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(have_q))
		else $error("seed flag dropped");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_rep_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		rep_pct_q != RESET_REPORTED |-> have_q)
		else $error("reported pair updated before first reading");

endmodule
`default_nettype wire
